// ===== hw/rtl/ghtab_pkg.sv =====
// Shared types and constants for the generational handle table.
`timescale 1ns / 1ps
`default_nettype none
package ghtab_pkg;

   localparam int SLOTS  = 64;
   localparam int SLOT_W = 6;
   localparam int CNT_W  = 7;
   localparam int GEN_W  = 32;

   localparam logic [1:0] OP_ALLOCATE = 2'd0;
   localparam logic [1:0] OP_FREE     = 2'd1;
   localparam logic [1:0] OP_RESOLVE  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0]        operation;
      logic [SLOT_W-1:0] slot_index;
      logic [GEN_W-1:0]  handle_generation;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] granted_slot;
      logic [GEN_W-1:0]  granted_generation;
   } rsp_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_EXEC
   } ctrl_state_type;

   typedef enum logic [2:0] {
      ACT_REUSE,
      ACT_APPEND,
      ACT_FULL,
      ACT_FREE,
      ACT_RESOLVE,
      ACT_INVALID
   } act_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ghtab_ctrl.sv =====
// Controller state machine: sequences capture and execute of each beat.
`timescale 1ns / 1ps
`default_nettype none
module ghtab_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  ghtab_pkg::dp_status_type   dp_status,
   output ghtab_pkg::ctrl_cmd_type    dp_cmd
);

   ghtab_pkg::ctrl_state_type state_ff;
   ghtab_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ghtab_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ghtab_pkg::CTRL_IDLE: begin
            if (req_valid) begin
               state_in = ghtab_pkg::CTRL_EXEC;
            end
         end
         ghtab_pkg::CTRL_EXEC: begin
            if (dp_status.out_free) begin
               state_in = ghtab_pkg::CTRL_IDLE;
            end
         end
         default: begin
            state_in = ghtab_pkg::CTRL_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall      = 1'b1;
      dp_cmd.capture = 1'b0;
      dp_cmd.execute = 1'b0;
      case (state_ff)
         ghtab_pkg::CTRL_IDLE: begin
            req_stall      = 1'b0;
            dp_cmd.capture = req_valid;
         end
         ghtab_pkg::CTRL_EXEC: begin
            dp_cmd.execute = dp_status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/ghtab_dp.sv =====
// Datapath: occupancy bits, high-water mark, generation memory and result register.
`timescale 1ns / 1ps
`default_nettype none
module ghtab_dp (
   input  wire                        clock,
   input  wire                        reset,
   input  ghtab_pkg::req_type         req_data,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output ghtab_pkg::rsp_type         rsp_data,
   input  ghtab_pkg::ctrl_cmd_type    dp_cmd,
   output ghtab_pkg::dp_status_type   dp_status
);

   logic [ghtab_pkg::SLOTS-1:0]  occupied_ff;
   logic [ghtab_pkg::SLOTS-1:0]  occupied_in;
   logic [ghtab_pkg::CNT_W-1:0]  mark_ff;
   logic [ghtab_pkg::CNT_W-1:0]  mark_in;
   logic [ghtab_pkg::GEN_W-1:0]  gen_mem [ghtab_pkg::SLOTS];
   logic [ghtab_pkg::GEN_W-1:0]  rd_ff;
   ghtab_pkg::act_type           act_ff;
   ghtab_pkg::act_type           act_in;
   logic [ghtab_pkg::SLOT_W-1:0] slot_ff;
   logic [ghtab_pkg::SLOT_W-1:0] slot_in;
   logic [ghtab_pkg::GEN_W-1:0]  hgen_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   ghtab_pkg::rsp_type           rsp_data_ff;
   ghtab_pkg::rsp_type           rsp_data_in;
   logic                         free_found;
   logic [ghtab_pkg::SLOT_W-1:0] free_slot;
   logic                         in_use;
   logic [ghtab_pkg::GEN_W-1:0]  gen_inc;
   logic [ghtab_pkg::GEN_W-1:0]  wr_gen;
   logic                         wr_en;

   // Lowest free slot below the mark.
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = ghtab_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!occupied_ff[i] && (ghtab_pkg::CNT_W'(i) < mark_ff)) begin
            free_found = 1'b1;
            free_slot  = ghtab_pkg::SLOT_W'(i);
         end
      end
   end

   assign in_use = {1'b0, req_data.slot_index} < mark_ff;

   always_comb begin
      act_in  = ghtab_pkg::ACT_INVALID;
      slot_in = req_data.slot_index;
      case (req_data.operation)
         ghtab_pkg::OP_ALLOCATE: begin
            if (free_found) begin
               act_in  = ghtab_pkg::ACT_REUSE;
               slot_in = free_slot;
            end else if (mark_ff < ghtab_pkg::CNT_W'(ghtab_pkg::SLOTS)) begin
               act_in  = ghtab_pkg::ACT_APPEND;
               slot_in = mark_ff[ghtab_pkg::SLOT_W-1:0];
            end else begin
               act_in  = ghtab_pkg::ACT_FULL;
               slot_in = '0;
            end
         end
         ghtab_pkg::OP_FREE: begin
            act_in = in_use ? ghtab_pkg::ACT_FREE : ghtab_pkg::ACT_INVALID;
         end
         ghtab_pkg::OP_RESOLVE: begin
            act_in = in_use ? ghtab_pkg::ACT_RESOLVE : ghtab_pkg::ACT_INVALID;
         end
         default: begin
            act_in = ghtab_pkg::ACT_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         act_ff  <= act_in;
         slot_ff <= slot_in;
         hgen_ff <= req_data.handle_generation;
         rd_ff   <= gen_mem[slot_in];
      end
   end

   // Raise the generation, skip zero.
   always_comb begin
      gen_inc = rd_ff + ghtab_pkg::GEN_W'(1);
      if (gen_inc == '0) begin
         gen_inc = ghtab_pkg::GEN_W'(1);
      end
   end

   always_comb begin
      occupied_in = occupied_ff;
      mark_in     = mark_ff;
      wr_en       = 1'b0;
      wr_gen      = gen_inc;
      rsp_data_in = rsp_data_ff;
      if (dp_cmd.execute) begin
         case (act_ff)
            ghtab_pkg::ACT_REUSE: begin
               wr_en                = 1'b1;
               occupied_in[slot_ff] = 1'b1;
               rsp_data_in          = '{ghtab_pkg::STATUS_OK, slot_ff, gen_inc};
            end
            ghtab_pkg::ACT_APPEND: begin
               wr_en                = 1'b1;
               wr_gen               = ghtab_pkg::GEN_W'(1);
               occupied_in[slot_ff] = 1'b1;
               mark_in              = mark_ff + ghtab_pkg::CNT_W'(1);
               rsp_data_in          = '{ghtab_pkg::STATUS_OK, slot_ff,
                                        ghtab_pkg::GEN_W'(1)};
            end
            ghtab_pkg::ACT_FULL: begin
               rsp_data_in = '{ghtab_pkg::STATUS_FULL, '0, '0};
            end
            ghtab_pkg::ACT_FREE: begin
               wr_en                = 1'b1;
               occupied_in[slot_ff] = 1'b0;
               rsp_data_in          = '{ghtab_pkg::STATUS_OK, slot_ff, gen_inc};
            end
            ghtab_pkg::ACT_RESOLVE: begin
               if ((rd_ff == hgen_ff) && occupied_ff[slot_ff]) begin
                  rsp_data_in = '{ghtab_pkg::STATUS_OK, slot_ff, rd_ff};
               end else begin
                  rsp_data_in = '{ghtab_pkg::STATUS_INVALID, slot_ff, rd_ff};
               end
            end
            default: begin
               rsp_data_in = '{ghtab_pkg::STATUS_INVALID, slot_ff, '0};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         gen_mem[slot_ff] <= wr_gen;
      end
   end

   assign rsp_valid_in = dp_cmd.execute | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff  <= '0;
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occupied_ff  <= occupied_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign dp_status.out_free = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/generational_handle_table_core.sv =====
// Top level of the generational handle table: controller plus datapath.
// A request beat is captured, then executed once the output is free; its
// response is registered. No new beat is accepted until the last one has
// executed, since the registered generation read precedes its write-back.
// Reset clears the occupancy bits, the high-water mark and the controller;
// the generation memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module generational_handle_table_core (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  ghtab_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output ghtab_pkg::rsp_type  rsp_data
);

   ghtab_pkg::ctrl_cmd_type  dp_cmd;
   ghtab_pkg::dp_status_type dp_status;

   ghtab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   ghtab_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous beat still in flight");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response raised without an executing beat");

   a_full_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ghtab_pkg::STATUS_FULL) |->
      (rsp_data.granted_slot == '0 && rsp_data.granted_generation == '0))
      else $error("full response carries nonzero slot or generation");

   a_ok_gen_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ghtab_pkg::STATUS_OK) |->
      (rsp_data.granted_generation != '0))
      else $error("successful response carries generation zero");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the generational handle table core.
`timescale 1ns / 1ps
module tb;

   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam int RANDOM_BEATS = 1450;
   localparam int PROBE_ROWS = 24;
   localparam int DRAIN_LIMIT = 2000;

   typedef enum int {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIX
   } churn_mode_type;

   typedef struct packed {
      ghtab_pkg::req_type beat;
      logic               typed;
      ghtab_pkg::rsp_type want;
   } probe_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   ghtab_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   ghtab_pkg::rsp_type rsp_data;

   bit                          shadow_occupied [ghtab_pkg::SLOTS];
   logic [ghtab_pkg::GEN_W-1:0] shadow_generation [ghtab_pkg::SLOTS];
   int                          shadow_mark;

   ghtab_pkg::rsp_type pending_grants [$];
   int      mismatch_count = 0;
   int      send_idle_pct = 37;
   int      stall_idle_pct = 70;
   int      op_seen [4] = '{0, 0, 0, 0};
   int      full_seen = 0;
   int      match_seen = 0;

   probe_row_type probe_table [PROBE_ROWS] = '{
      {ghtab_pkg::OP_RESOLVE,  6'd0,  32'd0,  1'b1, ghtab_pkg::STATUS_INVALID, 6'd0,  32'd0},
      {ghtab_pkg::OP_FREE,     6'd63, 32'hFFFF_FFFF,
       1'b1, ghtab_pkg::STATUS_INVALID, 6'd63, 32'd0},
      {OP_UNKNOWN,             6'd42, 32'd0,  1'b1, ghtab_pkg::STATUS_INVALID, 6'd42, 32'd0},
      {ghtab_pkg::OP_ALLOCATE, 6'd0,  32'd0,  1'b1, ghtab_pkg::STATUS_OK,      6'd0,  32'd1},
      {ghtab_pkg::OP_ALLOCATE, 6'd63, 32'hFFFF_FFFF,
       1'b1, ghtab_pkg::STATUS_OK, 6'd1, 32'd1},
      {ghtab_pkg::OP_ALLOCATE, 6'd21, 32'd0,  1'b1, ghtab_pkg::STATUS_OK,      6'd2,  32'd1},
      {ghtab_pkg::OP_RESOLVE,  6'd1,  32'd1,          1'b0, 40'd0},
      {ghtab_pkg::OP_RESOLVE,  6'd1,  32'hFFFF_FFFF,  1'b0, 40'd0},
      {ghtab_pkg::OP_FREE,     6'd1,  32'd0,          1'b0, 40'd0},
      {ghtab_pkg::OP_FREE,     6'd1,  32'd0,          1'b0, 40'd0},
      {ghtab_pkg::OP_RESOLVE,  6'd1,  32'd3,          1'b0, 40'd0},
      {ghtab_pkg::OP_ALLOCATE, 6'd0,  32'd0,          1'b0, 40'd0},
      {ghtab_pkg::OP_RESOLVE,  6'd1,  32'd4,          1'b0, 40'd0},
      {ghtab_pkg::OP_FREE,     6'd2,  32'hFFFF_FFFF,  1'b0, 40'd0},
      {ghtab_pkg::OP_FREE,     6'd3,  32'd0,  1'b1, ghtab_pkg::STATUS_INVALID, 6'd3,  32'd0},
      {ghtab_pkg::OP_RESOLVE,  6'd63, 32'hFFFF_FFFF,
       1'b1, ghtab_pkg::STATUS_INVALID, 6'd63, 32'd0},
      {OP_UNKNOWN,             6'd0,  32'hFFFF_FFFF,
       1'b1, ghtab_pkg::STATUS_INVALID, 6'd0, 32'd0},
      {ghtab_pkg::OP_FREE,     6'd0,  32'd0,          1'b0, 40'd0},
      {ghtab_pkg::OP_ALLOCATE, 6'd0,  32'd0,          1'b0, 40'd0},
      {ghtab_pkg::OP_ALLOCATE, 6'd0,  32'd0,          1'b0, 40'd0},
      {ghtab_pkg::OP_ALLOCATE, 6'd0,  32'd0,          1'b0, 40'd0},
      {ghtab_pkg::OP_RESOLVE,  6'd3,  32'd1,          1'b0, 40'd0},
      {ghtab_pkg::OP_RESOLVE,  6'd0,  32'd0,          1'b0, 40'd0},
      {ghtab_pkg::OP_RESOLVE,  6'd2,  32'hFFFF_FFFF,  1'b0, 40'd0}
   };

   generational_handle_table_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   task automatic enqueue_grant(input ghtab_pkg::rsp_type g);
      pending_grants.insert(pending_grants.size(), g);
   endtask

   function automatic logic [ghtab_pkg::GEN_W-1:0] bump_generation(
      input logic [ghtab_pkg::GEN_W-1:0] g);
      return (g == {ghtab_pkg::GEN_W{1'b1}}) ? ghtab_pkg::GEN_W'(1) : g + ghtab_pkg::GEN_W'(1);
   endfunction

   function automatic ghtab_pkg::rsp_type apply_handle_op(input ghtab_pkg::req_type r);
      ghtab_pkg::rsp_type o;
      int                 slot;
      int                 hit;
      bit                 in_use;
      o.status = ghtab_pkg::STATUS_INVALID;
      o.granted_slot = r.slot_index;
      o.granted_generation = '0;
      slot = int'(r.slot_index);
      in_use = slot < shadow_mark;
      case (r.operation)
         ghtab_pkg::OP_ALLOCATE: begin
            hit = -1;
            for (int i = 0; i < shadow_mark; i++)
               if (hit < 0 && !shadow_occupied[i]) hit = i;
            if (hit >= 0) begin
               shadow_generation[hit] = bump_generation(shadow_generation[hit]);
               shadow_occupied[hit] = 1'b1;
               o.status = ghtab_pkg::STATUS_OK;
               o.granted_slot = ghtab_pkg::SLOT_W'(hit);
               o.granted_generation = shadow_generation[hit];
            end else if (shadow_mark < ghtab_pkg::SLOTS) begin
               shadow_generation[shadow_mark] = ghtab_pkg::GEN_W'(1);
               shadow_occupied[shadow_mark] = 1'b1;
               o.status = ghtab_pkg::STATUS_OK;
               o.granted_slot = ghtab_pkg::SLOT_W'(shadow_mark);
               o.granted_generation = ghtab_pkg::GEN_W'(1);
               shadow_mark++;
            end else begin
               o.status = ghtab_pkg::STATUS_FULL;
               o.granted_slot = '0;
            end
         end
         ghtab_pkg::OP_FREE: begin
            if (in_use) begin
               shadow_occupied[slot] = 1'b0;
               shadow_generation[slot] = bump_generation(shadow_generation[slot]);
               o.status = ghtab_pkg::STATUS_OK;
               o.granted_generation = shadow_generation[slot];
            end
         end
         ghtab_pkg::OP_RESOLVE: begin
            if (in_use) begin
               o.granted_generation = shadow_generation[slot];
               if (shadow_generation[slot] == r.handle_generation && shadow_occupied[slot])
                  o.status = ghtab_pkg::STATUS_OK;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic ghtab_pkg::req_type random_beat(input churn_mode_type mode);
      ghtab_pkg::req_type b;
      int                 roll;
      int                 alloc_cut;
      int                 free_cut;
      int                 idx;
      roll = $urandom_range(99);
      case (mode)
         MODE_FILL: begin
            alloc_cut = 80;
            free_cut = 87;
         end
         MODE_DRAIN: begin
            alloc_cut = 10;
            free_cut = 70;
         end
         default: begin
            alloc_cut = 35;
            free_cut = 65;
         end
      endcase
      if (shadow_mark > 0 && $urandom_range(99) < 85) idx = $urandom_range(shadow_mark - 1);
      else idx = $urandom_range(ghtab_pkg::SLOTS - 1);
      b.slot_index = ghtab_pkg::SLOT_W'(idx);
      b.handle_generation = $urandom();
      if (roll < 3) b.operation = OP_UNKNOWN;
      else if (roll < alloc_cut) b.operation = ghtab_pkg::OP_ALLOCATE;
      else if (roll < free_cut) b.operation = ghtab_pkg::OP_FREE;
      else begin
         b.operation = ghtab_pkg::OP_RESOLVE;
         roll = $urandom_range(99);
         if (roll < 60) b.handle_generation = shadow_generation[idx];
         else if (roll < 75)
            b.handle_generation = shadow_generation[idx] + ghtab_pkg::GEN_W'(1);
      end
      return b;
   endfunction

   task automatic send_request(input ghtab_pkg::req_type beat, input logic typed,
                               input ghtab_pkg::rsp_type typed_want);
      ghtab_pkg::rsp_type grant;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      grant = apply_handle_op(beat);
      op_seen[beat.operation]++;
      if (grant.status == ghtab_pkg::STATUS_FULL) full_seen++;
      if (beat.operation == ghtab_pkg::OP_RESOLVE && grant.status == ghtab_pkg::STATUS_OK)
         match_seen++;
      enqueue_grant(typed ? typed_want : grant);
   endtask

   always @(posedge clock) begin : rsp_check
      ghtab_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            flag_mismatch($sformatf("response beat with nothing pending: %p", rsp_data));
         end else begin
            want = pending_grants.pop_front();
            if (rsp_data.status !== want.status)
               flag_mismatch($sformatf("status %0d, want %0d", rsp_data.status, want.status));
            if (rsp_data.granted_slot !== want.granted_slot)
               flag_mismatch($sformatf("granted_slot %0d, want %0d",
                                       rsp_data.granted_slot, want.granted_slot));
            if (rsp_data.granted_generation !== want.granted_generation)
               flag_mismatch($sformatf("granted_generation %0h, want %0h",
                                       rsp_data.granted_generation, want.granted_generation));
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < stall_idle_pct);
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int             n;
      int             drain_cycles;
      int             left_in_mode;
      churn_mode_type mode;
      for (n = 0; n < ghtab_pkg::SLOTS; n++) begin
         shadow_occupied[n] = 1'b0;
         shadow_generation[n] = '0;
      end
      shadow_mark = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < PROBE_ROWS; n++)
         send_request(probe_table[n].beat, probe_table[n].typed, probe_table[n].want);

      mode = MODE_FILL;
      left_in_mode = 64;
      for (n = 0; n < RANDOM_BEATS; n++) begin
         if (n == RANDOM_BEATS / 3) begin
            send_idle_pct = 70;
            stall_idle_pct = 37;
         end
         if (n == 2 * RANDOM_BEATS / 3) begin
            send_idle_pct = 0;
            stall_idle_pct = 0;
         end
         if (left_in_mode == 0) begin
            mode = churn_mode_type'($urandom_range(2));
            left_in_mode = $urandom_range(20, 90);
         end
         left_in_mode--;
         send_request(random_beat(mode), 1'b0, '0);
      end
      req_valid <= 1'b0;

      drain_cycles = 0;
      while (pending_grants.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (8) @(posedge clock);
      if (pending_grants.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", pending_grants.size()));

      $display("Covered %0d requests (%0d allocate, %0d free, %0d resolve, %0d unknown op)",
               op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
               op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
      $display("under three idle mixes; %0d table-full replies, %0d resolve hits, %0d mismatches.",
               full_seen, match_seen, mismatch_count);
      if (mismatch_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ghtab_pkg.sv
hw/rtl/ghtab_ctrl.sv
hw/rtl/ghtab_dp.sv
hw/rtl/generational_handle_table_core.sv
sim/tb.sv
